>>> rtl/core/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants of the integer to ASCII formatter
// Base codes, character codes, BCD sizing and the digit-to-ASCII table.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Base select codes as they arrive on the input port
  typedef enum logic [1:0] {
    BASE_BIN = 2'd0,
    BASE_OCT = 2'd1,
    BASE_DEC = 2'd2,
    BASE_HEX = 2'd3
  } base_e;

  localparam int unsigned DIGIT_BUFFER_DEPTH_DEF = 64;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned BCD_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Map one digit to its uppercase ASCII code
  function automatic logic [7:0] digit_char(logic [3:0] digit);
    logic [7:0] ch;
    case (digit)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'hA: ch = 8'h41;
      4'hB: ch = 8'h42;
      4'hC: ch = 8'h43;
      4'hD: ch = 8'h44;
      4'hE: ch = 8'h45;
      default: ch = 8'h46;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/i2a_bcd_conv.sv
// ----------------------------------------------------------------------------
// i2a_bcd_conv: bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one magnitude bit per cycle, 32 bits narrow or 64 wide.
// ----------------------------------------------------------------------------
module i2a_bcd_conv (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               narrow_i,
  input  logic [i2a_pkg::VALUE_W-1:0]        value_i,
  output logic                               done_o,
  output logic [i2a_pkg::BCD_W-1:0]          bcd_o
);

  logic [i2a_pkg::VALUE_W-1:0] bin_q, bin_d;
  logic [i2a_pkg::BCD_W-1:0]   bcd_q, bcd_d;
  logic [i2a_pkg::BCD_W-1:0]   bcd_adj;
  logic [6:0]                  cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  // Add 3 to every digit of five or more before the next shift
  always_comb begin
    logic [3:0] dig;
    dig = '0;
    for (int i = 0; i < int'(i2a_pkg::BCD_DIGITS); i++) begin
      dig = bcd_q[4*i +: 4];
      bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = narrow_i ? {value_i[31:0], 32'd0} : value_i;
      bcd_d  = '0;
      cnt_d  = narrow_i ? 7'd32 : 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[i2a_pkg::BCD_W-2:0], bin_q[i2a_pkg::VALUE_W-1]};
      bin_d = {bin_q[i2a_pkg::VALUE_W-2:0], 1'b0};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      bin_q  <= bin_d;
      bcd_q  <= bcd_d;
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

>>> rtl/core/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf-style integer to ASCII text formatter
// Formats one integer per transaction and streams its text one character
// per output transaction, with last on the final character.
// ----------------------------------------------------------------------------
// One number is handled at a time. After the input transaction the block
// handles the sign in ST_PREP, then for decimal runs the bit-serial BCD
// converter on the narrow or wide magnitude and collects its result. A
// leading-zero scan then drops one digit per cycle, up to the digit count
// of the base minus one (63 for wide binary, 21 octal, 19 decimal, 15 hex;
// about half for narrow values). ST_LAYOUT works out the field layout, and
// then the characters go out section by section, with a step to leave
// each section that comes before the one holding the final character
// (leading spaces, sign, zero fill and precision zeros always, the digits
// too when trailing spaces follow). Stalls on the output side hold the
// text back. The next number is taken as soon as the final character sits
// in the output register, while that character still waits to be taken.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
  parameter int unsigned DIGIT_BUFFER_DEPTH = i2a_pkg::DIGIT_BUFFER_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Number transaction
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] value_i,
  input  logic        is_wide_i,
  input  logic [1:0]  base_select_i,
  input  logic        is_signed_i,
  input  logic [5:0]  width_i,
  input  logic [5:0]  precision_i,
  input  logic        left_justify_i,
  input  logic        zero_pad_i,

  // Character transaction
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_char_o,
  output logic        last_o
);

  // Digits kept at most; digit slots of a base beyond this are dropped
  localparam logic [6:0] DepthLim = 7'(DIGIT_BUFFER_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CONV,
    ST_SCAN,
    ST_LAYOUT,
    ST_LEAD,
    ST_SIGN,
    ST_ZFILL,
    ST_PZERO,
    ST_DIGIT,
    ST_TRAIL
  } state_e;

  state_e            state_q, state_d;

  // Captured number and controls
  logic [63:0]       val_q, val_d;
  logic              wide_q, wide_d;
  i2a_pkg::base_e    base_q, base_d;
  logic              sgn_q, sgn_d;
  logic [5:0]        width_q, width_d;
  logic [5:0]        prec_q, prec_d;
  logic              left_q, left_d;
  logic              zpad_q, zpad_d;

  // Digit shift register, most significant digit at the top
  logic [79:0]       src_q, src_d;
  logic [6:0]        rem_q, rem_d;
  logic              seen_q, seen_d;

  // Layout
  logic              neg_q, neg_d;
  logic [6:0]        nd_q, nd_d;
  logic [5:0]        fill_q, fill_d;
  logic [5:0]        pz_q, pz_d;
  logic [6:0]        tot_q, tot_d;
  logic [6:0]        cnt_q, cnt_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  // Converter hookup
  logic              conv_start;
  logic [63:0]       conv_value;
  logic              conv_done;
  logic [79:0]       conv_bcd;

  // Combinational helpers
  logic [63:0]       ext_val;
  logic              neg_now;
  logic [63:0]       mag;
  logic [6:0]        nd_max;
  logic [3:0]        top_digit;
  logic [79:0]       src_shift;
  logic [6:0]        dig_field;
  logic [6:0]        sign_field;
  logic [6:0]        width_ext;
  logic [6:0]        phase_len;
  logic [7:0]        phase_char;
  state_e            phase_next;
  logic              can_emit;

  i2a_bcd_conv u_bcd_conv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (conv_start),
    .narrow_i (!wide_q),
    .value_i  (conv_value),
    .done_o   (conv_done),
    .bcd_o    (conv_bcd)
  );

  // Extend the narrow value, then take the magnitude of a negative one
  assign ext_val = wide_q ? val_q :
                   (sgn_q ? {{32{val_q[31]}}, val_q[31:0]} : {32'd0, val_q[31:0]});
  assign neg_now = sgn_q && ext_val[63];
  assign mag     = neg_now ? (64'd0 - ext_val) : ext_val;

  assign conv_start = (state_q == ST_PREP) && (base_q == i2a_pkg::BASE_DEC);
  assign conv_value = mag;

  // Digit slots of each base, top digit and digit shift
  always_comb begin
    case (base_q)
      i2a_pkg::BASE_BIN: begin
        nd_max    = wide_q ? 7'd64 : 7'd32;
        top_digit = {3'd0, src_q[79]};
        src_shift = {src_q[78:0], 1'b0};
      end
      i2a_pkg::BASE_OCT: begin
        nd_max    = wide_q ? 7'd22 : 7'd11;
        top_digit = {1'b0, src_q[79:77]};
        src_shift = {src_q[76:0], 3'd0};
      end
      i2a_pkg::BASE_DEC: begin
        nd_max    = wide_q ? 7'd20 : 7'd10;
        top_digit = src_q[79:76];
        src_shift = {src_q[75:0], 4'd0};
      end
      default: begin
        nd_max    = wide_q ? 7'd16 : 7'd8;
        top_digit = src_q[79:76];
        src_shift = {src_q[75:0], 4'd0};
      end
    endcase
  end

  // Digit field is the larger of precision and digit count
  assign dig_field  = ({1'b0, prec_q} > nd_q) ? {1'b0, prec_q} : nd_q;
  assign sign_field = dig_field + {6'd0, neg_q};
  assign width_ext  = {1'b0, width_q};

  // Length, character and successor of each output section
  always_comb begin
    phase_len  = '0;
    phase_char = i2a_pkg::CHAR_SPACE;
    phase_next = ST_IDLE;
    case (state_q)
      ST_LEAD: begin
        phase_len  = (!left_q && !zpad_q) ? {1'b0, fill_q} : 7'd0;
        phase_char = i2a_pkg::CHAR_SPACE;
        phase_next = ST_SIGN;
      end
      ST_SIGN: begin
        phase_len  = {6'd0, neg_q};
        phase_char = i2a_pkg::CHAR_MINUS;
        phase_next = ST_ZFILL;
      end
      ST_ZFILL: begin
        phase_len  = (!left_q && zpad_q) ? {1'b0, fill_q} : 7'd0;
        phase_char = i2a_pkg::CHAR_ZERO;
        phase_next = ST_PZERO;
      end
      ST_PZERO: begin
        phase_len  = {1'b0, pz_q};
        phase_char = i2a_pkg::CHAR_ZERO;
        phase_next = ST_DIGIT;
      end
      ST_DIGIT: begin
        phase_len  = nd_q;
        phase_char = i2a_pkg::digit_char(top_digit);
        phase_next = ST_TRAIL;
      end
      ST_TRAIL: begin
        phase_len  = left_q ? {1'b0, fill_q} : 7'd0;
        phase_char = i2a_pkg::CHAR_SPACE;
        phase_next = ST_IDLE;
      end
      default: begin
        phase_len  = '0;
        phase_char = i2a_pkg::CHAR_SPACE;
        phase_next = ST_IDLE;
      end
    endcase
  end

  // Output register is free or being drained this cycle
  assign can_emit = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    wide_d      = wide_q;
    base_d      = base_q;
    sgn_d       = sgn_q;
    width_d     = width_q;
    prec_d      = prec_q;
    left_d      = left_q;
    zpad_d      = zpad_q;
    src_d       = src_q;
    rem_d       = rem_q;
    seen_d      = seen_q;
    neg_d       = neg_q;
    nd_d        = nd_q;
    fill_d      = fill_q;
    pz_d        = pz_q;
    tot_d       = tot_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    // Drop the held character once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d   = value_i;
          wide_d  = is_wide_i;
          base_d  = i2a_pkg::base_e'(base_select_i);
          sgn_d   = is_signed_i && (i2a_pkg::base_e'(base_select_i) == i2a_pkg::BASE_DEC);
          width_d = width_i;
          prec_d  = precision_i;
          left_d  = left_justify_i;
          zpad_d  = zero_pad_i;
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        neg_d  = neg_now;
        rem_d  = nd_max;
        seen_d = 1'b0;
        case (base_q)
          i2a_pkg::BASE_BIN: begin
            src_d   = wide_q ? {mag, 16'd0} : {mag[31:0], 48'd0};
            state_d = ST_SCAN;
          end
          i2a_pkg::BASE_OCT: begin
            src_d   = wide_q ? {2'd0, mag, 14'd0} : {1'b0, mag[31:0], 47'd0};
            state_d = ST_SCAN;
          end
          i2a_pkg::BASE_DEC: begin
            state_d = ST_CONV;
          end
          default: begin
            src_d   = wide_q ? {mag, 16'd0} : {mag[31:0], 48'd0};
            state_d = ST_SCAN;
          end
        endcase
      end
      ST_CONV: begin
        if (conv_done) begin
          src_d   = wide_q ? conv_bcd : {conv_bcd[39:0], 40'd0};
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rem_q > DepthLim) begin
          // Beyond the digit buffer: drop, but remember a nonzero digit
          seen_d = seen_q || (top_digit != 4'd0);
          src_d  = src_shift;
          rem_d  = rem_q - 7'd1;
        end else if ((rem_q > 7'd1) && (top_digit == 4'd0) && !seen_q) begin
          src_d = src_shift;
          rem_d = rem_q - 7'd1;
        end else begin
          nd_d    = rem_q;
          state_d = ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        fill_d  = (width_ext > sign_field) ? 6'(width_ext - sign_field) : 6'd0;
        pz_d    = 6'(dig_field - nd_q);
        tot_d   = ((width_ext > sign_field) ? width_ext : sign_field);
        cnt_d   = '0;
        state_d = ST_LEAD;
      end
      ST_LEAD, ST_SIGN, ST_ZFILL, ST_PZERO, ST_DIGIT, ST_TRAIL: begin
        if (cnt_q == phase_len) begin
          cnt_d   = '0;
          state_d = phase_next;
        end else if (can_emit) begin
          out_valid_d = 1'b1;
          out_char_d  = phase_char;
          out_last_d  = (tot_q == 7'd1);
          cnt_d       = cnt_q + 7'd1;
          tot_d       = tot_q - 7'd1;
          if (state_q == ST_DIGIT) begin
            src_d = src_shift;
          end
          // Final character loaded: free the input side at once
          if (tot_q == 7'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      seen_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      seen_q      <= seen_d;
      val_q       <= val_d;
      wide_q      <= wide_d;
      base_q      <= base_d;
      sgn_q       <= sgn_d;
      width_q     <= width_d;
      prec_q      <= prec_d;
      left_q      <= left_d;
      zpad_q      <= zpad_d;
      src_q       <= src_d;
      rem_q       <= rem_d;
      neg_q       <= neg_d;
      nd_q        <= nd_d;
      fill_q      <= fill_d;
      pz_q        <= pz_d;
      tot_q       <= tot_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

>>> rtl/core/i2a_checker.sv
// ----------------------------------------------------------------------------
// i2a_checker: port-level assertions for the integer to ASCII formatter
// Watches the number and character transactions at the top-level ports.
// ----------------------------------------------------------------------------
module i2a_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_o,
  input  logic        out_valid_o,
  input  logic        out_ready_i,
  input  logic [7:0]  out_char_o,
  input  logic        last_o
);

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o) && $stable(last_o))
    else $error("character changed while stalled");

  // One number at a time: busy right after a number transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction");

  // No character appears out of an idle, drained block
  a_quiet_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("character from an idle block");

  // Going idle coincides with the final character being presented
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && last_o)
    else $error("idle without a final character");

  // A character that is not final means the number is still in progress
  a_mid_text_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of a text");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_char_o  (out_char_o),
  .last_o      (last_o)
);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of integer_to_ascii_formatter
// Drives directed and random numbers with formatting controls, predicts the printf-style
// text of each one and checks every character and its last flag in order,
// under random gaps, random output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_TEXT     = 64;
  localparam int unsigned STALL_LIMIT  = 5000;  // cycles with work but no transaction
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned RANDOM_ITEMS = 262;

  // One number transaction as it sits on the input ports
  typedef struct {
    logic [63:0]    value;
    logic           is_wide;
    i2a_pkg::base_e base;
    logic           is_signed;
    logic [5:0]     width;
    logic [5:0]     precision;
    logic           left_justify;
    logic           zero_pad;
  } number_t;

  // One expected character, tagged with the number it belongs to
  typedef struct {
    logic [7:0] ch;
    logic       last;
    int         number_idx;
    int         char_idx;
  } text_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [63:0] value_i;
  logic        is_wide_i;
  logic [1:0]  base_select_i;
  logic        is_signed_i;
  logic [5:0]  width_i;
  logic [5:0]  precision_i;
  logic        left_justify_i;
  logic        zero_pad_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_char_o;
  logic        last_o;

  text_char_t  pending_chars[$];   // text still owed by the formatter
  int          numbers_sent  = 0;
  int          error_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hold_off_len  = 0;  // request for a long output hold-off
  bit          src_gaps_on   = 1'b0;
  bit          sink_stalls_on = 1'b0;

  integer_to_ascii_formatter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .value_i        (value_i),
    .is_wide_i      (is_wide_i),
    .base_select_i  (base_select_i),
    .is_signed_i    (is_signed_i),
    .width_i        (width_i),
    .precision_i    (precision_i),
    .left_justify_i (left_justify_i),
    .zero_pad_i     (zero_pad_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_char_o     (out_char_o),
    .last_o         (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Text prediction
  // --------------------------------------------------------------------------

  // Work out the full text of one number and queue it as expected characters.
  function automatic void format_number(input number_t n, input int idx);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] rem;
    logic [7:0]  digits[$];  // least significant first
    logic [7:0]  text[$];
    text_char_t  tc;
    bit          dec_signed;
    bit          minus;
    int          n_dig;
    int          field;
    int          fill;
    dec_signed = n.is_signed && (n.base == i2a_pkg::BASE_DEC);
    // Narrow values: sign-extend only for signed decimal, else zero-extend
    if (n.is_wide)
      mag = n.value;
    else if (dec_signed)
      mag = {{32{n.value[31]}}, n.value[31:0]};
    else
      mag = {32'd0, n.value[31:0]};
    minus = dec_signed && mag[63];
    if (minus)
      mag = -mag;  // most negative value wraps to its own magnitude
    case (n.base)
      i2a_pkg::BASE_BIN: radix = 64'd2;
      i2a_pkg::BASE_OCT: radix = 64'd8;
      i2a_pkg::BASE_DEC: radix = 64'd10;
      default:           radix = 64'd16;
    endcase
    // Zero still yields one digit
    do begin
      rem = mag % radix;
      digits.push_back((rem < 10) ? 8'h30 + rem[7:0] : 8'h37 + rem[7:0]);
      mag = mag / radix;
    end while (mag != 0 && digits.size() < 64);
    n_dig = digits.size();
    field = (int'(n.precision) > n_dig) ? int'(n.precision) : n_dig;
    fill  = int'(n.width) - int'(minus) - field;
    if (fill < 0)
      fill = 0;

    if (!n.left_justify && !n.zero_pad)
      repeat (fill) text.push_back(i2a_pkg::CHAR_SPACE);
    if (minus)
      text.push_back(i2a_pkg::CHAR_MINUS);
    if (!n.left_justify && n.zero_pad)
      repeat (fill) text.push_back(i2a_pkg::CHAR_ZERO);
    repeat (field - n_dig) text.push_back(i2a_pkg::CHAR_ZERO);
    for (int k = n_dig - 1; k >= 0; k--)
      text.push_back(digits[k]);
    if (n.left_justify)
      repeat (fill) text.push_back(i2a_pkg::CHAR_SPACE);
    while (text.size() > MAX_TEXT)
      void'(text.pop_back());

    foreach (text[k]) begin
      tc.ch         = text[k];
      tc.last       = (k == text.size() - 1);
      tc.number_idx = idx;
      tc.char_idx   = k;
      pending_chars.push_back(tc);
    end
  endfunction

  function automatic number_t number_of(input logic [63:0] value, input logic wide,
                                        input i2a_pkg::base_e base, input logic sgn,
                                        input int width, input int prec,
                                        input logic left, input logic zpad);
    number_t n;
    n.value        = value;
    n.is_wide      = wide;
    n.base         = base;
    n.is_signed    = sgn;
    n.width        = width[5:0];
    n.precision    = prec[5:0];
    n.left_justify = left;
    n.zero_pad     = zpad;
    return n;
  endfunction

  // Values weighted toward zero, small magnitudes, sign boundaries and powers of two
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(6))
      0:       v = 64'($urandom_range(20));
      1:       v = {$urandom(), $urandom()};
      2:       v = -64'($urandom_range(1, 20));
      3:       v = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
      4:       v = {$urandom(), 32'h8000_0000 - $urandom_range(1)};
      5:       v = {$urandom_range(1) ? 32'hFFFF_FFFF : 32'd0, $urandom()};
      default: v = {$urandom(), $urandom()} >> $urandom_range(63);
    endcase
    return v;
  endfunction

  function automatic number_t random_number();
    number_t n;
    n.value        = random_value();
    n.is_wide      = 1'($urandom_range(1));
    n.base         = i2a_pkg::base_e'($urandom_range(3));
    n.is_signed    = 1'($urandom_range(1));
    n.width        = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(63));
    n.precision    = ($urandom_range(3) == 0) ? 6'd0 : 6'($urandom_range(63));
    n.left_justify = 1'($urandom_range(1));
    n.zero_pad     = 1'($urandom_range(1));
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one number and hold it until the formatter takes it. Called on a
  // rising edge; returns on the edge of the transaction with valid still high.
  task automatic send_number(input number_t n);
    while (src_gaps_on && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    value_i        <= n.value;
    is_wide_i      <= n.is_wide;
    base_select_i  <= n.base;
    is_signed_i    <= n.is_signed;
    width_i        <= n.width;
    precision_i    <= n.precision;
    left_justify_i <= n.left_justify;
    zero_pad_i     <= n.zero_pad;
    do @(posedge clk_i); while (!in_ready_o);
    format_number(n, numbers_sent);
    numbers_sent++;
  endtask

  // Drop valid and wait until every owed character has come out
  task automatic wait_text_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0)
      @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------

  // Ready with random stalls; a hold-off request keeps it low for a counted stretch
  initial begin : char_sink
    int unsigned hold_left;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        hold_left    = hold_off_len;
        hold_off_len = 0;
        out_ready_i <= 1'b0;
        while (hold_left != 0) begin
          @(posedge clk_i);
          hold_left--;
        end
      end else begin
        out_ready_i <= !(sink_stalls_on && $urandom_range(99) < 13);
      end
    end
  end

  task automatic flag_mismatch(input string what);
    if (error_count < 100)
      $display("mismatch: %s", what);
    error_count++;
  endtask

  // Compare each character transaction with the oldest expectation
  always @(posedge clk_i) begin
    text_char_t exp_c;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_chars.size() == 0) begin
        flag_mismatch($sformatf("unexpected char %h last %b", out_char_o, last_o));
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char_o !== exp_c.ch)
          flag_mismatch($sformatf("number %0d char %0d: out_char %h, want %h",
                                  exp_c.number_idx, exp_c.char_idx, out_char_o, exp_c.ch));
        if (last_o !== exp_c.last)
          flag_mismatch($sformatf("number %0d char %0d: last %b, want %b",
                                  exp_c.number_idx, exp_c.char_idx, last_o, exp_c.last));
      end
    end
  end

  // Abort when work is outstanding but no transaction happens for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (!in_valid_i && pending_chars.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Extremes of the value in every base, zero, sign handling
  task automatic test_special_values();
    send_number(number_of(64'd0, 1'b1, i2a_pkg::BASE_BIN, 1'b0, 0, 0, 1'b0, 1'b0));
    send_number(number_of(64'd0, 1'b0, i2a_pkg::BASE_DEC, 1'b1, 0, 0, 1'b0, 1'b0));
    send_number(number_of('1, 1'b1, i2a_pkg::BASE_BIN, 1'b0, 0, 0, 1'b0, 1'b0));
    send_number(number_of('1, 1'b1, i2a_pkg::BASE_OCT, 1'b0, 0, 0, 1'b0, 1'b0));
    send_number(number_of('1, 1'b1, i2a_pkg::BASE_DEC, 1'b0, 0, 0, 1'b0, 1'b0));
    send_number(number_of('1, 1'b1, i2a_pkg::BASE_HEX, 1'b0, 0, 0, 1'b0, 1'b0));
    // Signed flag outside decimal prints the raw magnitude
    send_number(number_of('1, 1'b1, i2a_pkg::BASE_HEX, 1'b1, 0, 0, 1'b0, 1'b0));
    send_number(number_of(64'hFFFF_FFFF_8000_0000, 1'b0, i2a_pkg::BASE_OCT,
                          1'b1, 0, 0, 1'b0, 1'b0));
    // Most negative values, wide and narrow
    send_number(number_of(64'h8000_0000_0000_0000, 1'b1, i2a_pkg::BASE_DEC,
                          1'b1, 0, 0, 1'b0, 1'b0));
    send_number(number_of(64'h1234_5678_8000_0000, 1'b0, i2a_pkg::BASE_DEC,
                          1'b1, 0, 0, 1'b0, 1'b0));
    // Narrow: upper bits ignored, sign-extended only when signed decimal
    send_number(number_of(64'hDEAD_BEEF_FFFF_FFFF, 1'b0, i2a_pkg::BASE_DEC,
                          1'b1, 0, 0, 1'b0, 1'b0));
    send_number(number_of(64'hDEAD_BEEF_FFFF_FFFF, 1'b0, i2a_pkg::BASE_DEC,
                          1'b0, 0, 0, 1'b0, 1'b0));
    send_number(number_of(64'h0123_4567_89AB_CDEF, 1'b1, i2a_pkg::BASE_HEX,
                          1'b0, 0, 0, 1'b0, 1'b0));
    send_number(number_of(64'h7FFF_FFFF_FFFF_FFFF, 1'b1, i2a_pkg::BASE_DEC,
                          1'b1, 0, 0, 1'b0, 1'b0));
  endtask

  // Width, precision, zero fill and left justify around a sign
  task automatic test_field_layout();
    send_number(number_of(-64'd42, 1'b1, i2a_pkg::BASE_DEC, 1'b1, 63, 0, 1'b0, 1'b0));
    send_number(number_of(-64'd42, 1'b1, i2a_pkg::BASE_DEC, 1'b1, 63, 0, 1'b0, 1'b1));
    send_number(number_of(-64'd42, 1'b1, i2a_pkg::BASE_DEC, 1'b1, 63, 0, 1'b1, 1'b1));
    send_number(number_of(64'd7, 1'b0, i2a_pkg::BASE_OCT, 1'b0, 0, 63, 1'b0, 1'b0));
    send_number(number_of(64'd0, 1'b0, i2a_pkg::BASE_HEX, 1'b0, 10, 5, 1'b1, 1'b0));
    send_number(number_of(-64'd5, 1'b1, i2a_pkg::BASE_DEC, 1'b1, 12, 6, 1'b0, 1'b1));
    // Digits wider than both width and precision
    send_number(number_of('1, 1'b1, i2a_pkg::BASE_BIN, 1'b0, 63, 63, 1'b0, 1'b1));
    send_number(number_of(64'hABCD, 1'b1, i2a_pkg::BASE_HEX, 1'b0, 2, 1, 1'b0, 1'b0));
    send_number(number_of(64'd99, 1'b0, i2a_pkg::BASE_BIN, 1'b0, 63, 40, 1'b1, 1'b0));
  endtask

  // Random numbers; a long opening stretch runs with no gaps and no stalls
  task automatic test_random_mix();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 70) begin
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
      end
      send_number(random_number());
    end
  endtask

  // Hold the output off while numbers keep coming so the input stalls
  task automatic test_output_backpressure();
    hold_off_len = 400;
    repeat (12) send_number(random_number());
  endtask

  // Pause the input until all text is out, then resume
  task automatic test_drain_pause();
    repeat (6) send_number(random_number());
    wait_text_drained();
    repeat (6) send_number(random_number());
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    value_i        = '0;
    is_wide_i      = 1'b0;
    base_select_i  = i2a_pkg::BASE_BIN;
    is_signed_i    = 1'b0;
    width_i        = '0;
    precision_i    = '0;
    left_justify_i = 1'b0;
    zero_pad_i     = 1'b0;
    out_ready_i    = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_values();
    test_field_layout();
    test_random_mix();
    test_output_backpressure();
    test_drain_pause();

    wait_text_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

>>> integer_to_ascii_formatter.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_bcd_conv.sv
rtl/core/integer_to_ascii_formatter.sv
rtl/core/i2a_checker.sv
tb/tb.sv
